>>> src/float32_divide_by_reciprocal_unit_defines.svh
// Assertion macros for the float32 divide-by-reciprocal unit.
// Depends on nothing; the asserting file supplies clock and reset.
`ifndef FLOAT32_DIVIDE_BY_RECIPROCAL_UNIT_DEFINES_SVH
`define FLOAT32_DIVIDE_BY_RECIPROCAL_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FDR_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fdr assertion failed");

// Next-cycle implication, checked outside reset.
`define FDR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fdr assertion failed");

// Check that holds in every cycle, reset included.
`define FDR_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) (cond)) \
      else $error("fdr assertion failed");

`endif

>>> src/fdr_pkg.sv
// Package of the float32 divide-by-reciprocal unit: widths and the seed table.
// Used by fdr_recip, fdr_mul and the top level.
`timescale 1ns / 1ps

package fdr_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned ExpWidth  = 8;
   localparam int unsigned FracWidth = 23;
   localparam int unsigned MantWidth = FracWidth + 1;
   localparam int unsigned SeedWidth = 8;
   localparam int unsigned R1Width   = 13;

   typedef logic [SeedWidth-1:0] seed_type;

   function automatic seed_type seed_lookup(input logic [4:0] idx);
      seed_type r;
      case (idx)
         5'd0:  r = 8'h7E;  5'd1:  r = 8'h7A;  5'd2:  r = 8'h77;  5'd3:  r = 8'h73;
         5'd4:  r = 8'h70;  5'd5:  r = 8'h6D;  5'd6:  r = 8'h6A;  5'd7:  r = 8'h68;
         5'd8:  r = 8'h65;  5'd9:  r = 8'h63;  5'd10: r = 8'h60;  5'd11: r = 8'h5E;
         5'd12: r = 8'h5C;  5'd13: r = 8'h5A;  5'd14: r = 8'h58;  5'd15: r = 8'h56;
         5'd16: r = 8'h54;  5'd17: r = 8'h53;  5'd18: r = 8'h51;  5'd19: r = 8'h50;
         5'd20: r = 8'h4E;  5'd21: r = 8'h4D;  5'd22: r = 8'h4B;  5'd23: r = 8'h4A;
         5'd24: r = 8'h48;  5'd25: r = 8'h47;  5'd26: r = 8'h46;  5'd27: r = 8'h45;
         5'd28: r = 8'h44;  5'd29: r = 8'h43;  5'd30: r = 8'h42;  5'd31: r = 8'h41;
         default: r = 8'h41;
      endcase
      return r;
   endfunction

   // Pipeline control handed between the two halves
   typedef struct packed {
      logic enable;
      logic valid;
   } ctl_type;

endpackage

>>> src/float32_divide_by_reciprocal_unit.sv
// Channel   Ports                       Direction
// req       req_valid/ready, dividend,  in
//           divisor
// rsp       rsp_valid/ready, quotient   out
//
// Items pass through the register stages of the reciprocal half, then those of the multiply.
// One item is taken every cycle while the result side takes items.
// The whole pipeline holds when a result waits and rsp_ready is low.
// Reset clears the stage valid bits only.
// Top level: fdr_recip then fdr_mul; depends on fdr_pkg and the defines header.
`timescale 1ns / 1ps
`include "float32_divide_by_reciprocal_unit_defines.svh"

module float32_divide_by_reciprocal_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [fdr_pkg::WordWidth-1:0]     req_dividend,
   input  logic [fdr_pkg::WordWidth-1:0]     req_divisor,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [fdr_pkg::WordWidth-1:0]     rsp_quotient
);

   fdr_pkg::ctl_type                  ctl_req, ctl_mid;
   logic                              enable;
   logic                              mid_valid;
   logic [fdr_pkg::WordWidth-1:0]     mid_dividend;
   logic [fdr_pkg::WordWidth-1:0]     mid_recip;

   // advance everything unless a result sits untaken
   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;

   assign ctl_req = '{enable: enable, valid: req_valid};
   assign ctl_mid = '{enable: enable, valid: mid_valid};

   fdr_recip u_recip (
      .clock        (clock),
      .reset        (reset),
      .ctl_in       (ctl_req),
      .dividend     (req_dividend),
      .divisor      (req_divisor),
      .valid_out    (mid_valid),
      .dividend_out (mid_dividend),
      .recip_out    (mid_recip)
   );

   fdr_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (ctl_mid),
      .a         (mid_dividend),
      .b         (mid_recip),
      .valid_out (rsp_valid),
      .quotient  (rsp_quotient)
   );

   `FDR_ASSERT_IMPL(a_ready_follows_output, 1'b1, req_ready == (!rsp_valid || rsp_ready))
   `FDR_ASSERT_ALWAYS(a_reset_empties, !$past(reset) || !rsp_valid)
   `FDR_ASSERT_NEXT(a_stall_holds_mid, !enable && mid_valid, mid_valid && $stable(mid_recip))
   `FDR_ASSERT_NEXT(a_stall_holds_result, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_quotient))

endmodule

>>> src/fdr_recip.sv
// Reciprocal half: seed lookup and two Newton steps over five register stages.
// Depends on fdr_pkg.
`timescale 1ns / 1ps

module fdr_recip (
   input  logic                              clock,
   input  logic                              reset,
   input  fdr_pkg::ctl_type                  ctl_in,
   input  logic [fdr_pkg::WordWidth-1:0]     dividend,
   input  logic [fdr_pkg::WordWidth-1:0]     divisor,
   output logic                              valid_out,
   output logic [fdr_pkg::WordWidth-1:0]     dividend_out,
   output logic [fdr_pkg::WordWidth-1:0]     recip_out
);

   localparam int unsigned W = fdr_pkg::WordWidth;
   localparam int unsigned M = fdr_pkg::MantWidth;
   localparam int unsigned E = fdr_pkg::ExpWidth;
   localparam int unsigned R = fdr_pkg::R1Width;

   logic [4:0]  v_ff, v_in;
   logic        en;

   // stage 1
   fdr_pkg::seed_type g1_ff, g1_in;
   logic [15:0]  gg1_ff, gg1_in;
   logic [M-1:0] ma1_ff, ma2_ff, ma3_ff;
   logic         s1_ff, s2_ff, s3_ff, s4_ff;
   logic [E-1:0] e1_ff, e2_ff, e3_ff, e4_ff;
   logic [W-1:0] n1_ff, n2_ff, n3_ff, n4_ff, n5_ff;
   // stage 2
   logic [39:0]  prod1;
   logic [37:0]  t1;
   logic [12:0]  t1h2_ff, t1h2_in;
   // stage 3
   logic [R-1:0]   r13_ff, r13_in;
   logic [2*R-1:0] rr3_ff, rr3_in;
   // stage 4
   logic [2*R+M-1:0] prod2;
   logic [45:0]  t2;
   logic [25:0]  t2h4_ff, t2h4_in;
   // stage 5
   logic [E-1:0] ey;
   logic [M-1:0] fy;
   logic [W-1:0] b5_ff, b5_in;

   assign en = ctl_in.enable;
   assign v_in = {v_ff[3:0], ctl_in.valid};

   assign g1_in  = fdr_pkg::seed_lookup(divisor[22:18]);
   assign gg1_in = 16'(g1_in) * 16'(g1_in);

   // t1 = g*2^31 - g*g*ma, bits above 37 never reach the result
   assign prod1   = 40'(gg1_ff) * 40'(ma1_ff);
   assign t1      = {g1_ff[6:0], 31'd0} - prod1[37:0];
   assign t1h2_in = t1[37:25];

   assign r13_in = R'(t1h2_ff[12:1]) + R'(t1h2_ff[0]);
   assign rr3_in = (2*R)'(r13_in) * (2*R)'(r13_in);

   assign prod2   = (2*R+M)'(rr3_ff) * (2*R+M)'(ma3_ff);
   assign t2      = {r13_ff[10:0], 35'd0} - prod2[45:0];
   assign t2h4_in = t2[45:20];

   // t2h4 bit 25 is t2 bit 45: top bit present or not
   always_comb begin
      if (t2h4_ff[25]) begin
         ey = E'(9'd254 - {1'b0, e4_ff});
         fy = M'(t2h4_ff[24:2]) + M'(t2h4_ff[1]);
      end else begin
         ey = E'(9'd253 - {1'b0, e4_ff});
         fy = M'(t2h4_ff[23:1]) + M'(t2h4_ff[0]);
      end
   end
   // rounding carry may run into exponent and sign
   assign b5_in = {s4_ff, ey, 23'd0} + W'(fy);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g1_ff   <= g1_in;
         gg1_ff  <= gg1_in;
         ma1_ff  <= {1'b1, divisor[22:0]};
         s1_ff   <= divisor[31];
         e1_ff   <= divisor[30:23];
         n1_ff   <= dividend;
         t1h2_ff <= t1h2_in;
         ma2_ff  <= ma1_ff;
         s2_ff   <= s1_ff;
         e2_ff   <= e1_ff;
         n2_ff   <= n1_ff;
         r13_ff  <= r13_in;
         rr3_ff  <= rr3_in;
         ma3_ff  <= ma2_ff;
         s3_ff   <= s2_ff;
         e3_ff   <= e2_ff;
         n3_ff   <= n2_ff;
         t2h4_ff <= t2h4_in;
         s4_ff   <= s3_ff;
         e4_ff   <= e3_ff;
         n4_ff   <= n3_ff;
         b5_ff   <= b5_in;
         n5_ff   <= n4_ff;
      end
   end

   assign valid_out    = v_ff[4];
   assign dividend_out = n5_ff;
   assign recip_out    = b5_ff;

endmodule

>>> src/fdr_mul.sv
// Multiply half: mantissa product, then normalise, round and pack the quotient.
// Depends on fdr_pkg.
`timescale 1ns / 1ps

module fdr_mul (
   input  logic                              clock,
   input  logic                              reset,
   input  fdr_pkg::ctl_type                  ctl_in,
   input  logic [fdr_pkg::WordWidth-1:0]     a,
   input  logic [fdr_pkg::WordWidth-1:0]     b,
   output logic                              valid_out,
   output logic [fdr_pkg::WordWidth-1:0]     quotient
);

   localparam int unsigned M = fdr_pkg::MantWidth;
   localparam int unsigned E = fdr_pkg::ExpWidth;
   localparam int unsigned W = fdr_pkg::WordWidth;

   logic [1:0]     v_ff;
   logic [2*M-1:0] p_ff, p_in;
   logic [E-1:0]   ea_ff, eb_ff;
   logic           sy_ff;
   logic [W-1:0]   q_ff, q_in;

   logic           top;
   logic [46:0]    k;
   logic [M-1:0]   fy;
   logic [8:0]     sum;
   logic [8:0]     ex;
   logic [E-1:0]   ey;

   assign p_in = (2*M)'({1'b1, a[22:0]}) * (2*M)'({1'b1, b[22:0]});

   always_comb begin
      top = p_ff[47];
      k   = top ? p_ff[46:0] : {p_ff[45:0], 1'b0};
      // tie when the sticky bits are clear: round by the kept lsb
      if (k[22:0] == 23'd0 && k[23]) begin
         fy = M'(k[46:24]) + M'(k[24]);
      end else begin
         fy = M'(k[46:24]) + M'(k[23]);
      end
      sum = 9'(ea_ff) + 9'(eb_ff) + 9'(top) + 9'(k[46:23] == 24'hFFFFFF);
      if (sum[8] && sum[7]) begin
         ex = 9'h1FF;
      end else if (sum[8] || sum[7]) begin
         ex = sum - 9'd127;
      end else begin
         ex = 9'd0;
      end
      ey = ex[E-1:0];
      if (ea_ff != '0 || eb_ff != '0 || ey != '0) begin
         q_in = {sy_ff, ey, fy[22:0]};
      end else begin
         q_in = {sy_ff, 31'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (ctl_in.enable) begin
         v_ff <= {v_ff[0], ctl_in.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_in.enable) begin
         p_ff  <= p_in;
         ea_ff <= a[30:23];
         eb_ff <= b[30:23];
         sy_ff <= a[31] ^ b[31];
         q_ff  <= q_in;
      end
   end

   assign valid_out = v_ff[1];
   assign quotient  = q_ff;

endmodule
